### design/motor_move_to_position_unit_macros.svh
// Assertion helpers for the checker in mmp_checker.sv.
`ifndef MOTOR_MOVE_TO_POSITION_UNIT_MACROS_SVH
`define MOTOR_MOVE_TO_POSITION_UNIT_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define MMP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, quiet while reset is high.
`define MMP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication that also holds across reset.
`define MMP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication across reset");

`endif

### design/mmp_pkg.sv
`default_nettype none
package mmp_pkg;

  localparam int ADDR_W = 4;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_JOINT_ID   = 2'd0;
  localparam logic [1:0] REG_TGT_MODE   = 2'd1;
  localparam logic [1:0] REG_TGT_VALUE  = 2'd2;
  localparam logic [1:0] REG_BASE_EFF   = 2'd3;

  // move phases
  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_MOVE = 2'd1;
  localparam logic [1:0] PH_END  = 2'd2;

  // report kinds
  localparam logic KIND_EFFORT = 1'b0;
  localparam logic KIND_DONE   = 1'b1;

  // Q16.16 constants
  localparam logic signed [33:0] Q_WINDOW  = 34'sd6554;
  localparam logic signed [33:0] Q_LOW_TOL = 34'sd3277;
  localparam logic signed [31:0] Q_FAST    = 32'sd163840;
  localparam logic signed [31:0] Q_SLOW    = 32'sd65536;
  localparam logic signed [32:0] Q_STEP    = 33'sd66;

  typedef struct packed {
    logic [7:0]         my_joint_id;
    logic               target_mode;
    logic signed [31:0] target_value;
    logic [30:0]        base_effort;
  } cfg_t;

  typedef struct packed {
    logic               report_kind;
    logic signed [31:0] effort_cmd;
    logic signed [31:0] final_position;
  } res_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/motor_move_to_position_unit.sv
// Move-to-position effort controller for one motor joint.
// Input channel (in_valid/in_ready): joint-state samples, each with joint_id,
// position, velocity and measured_effort in signed Q16.16. Samples for other
// joints are dropped without a result.
// Output channel (out_valid/out_ready): at most one item per sample, either an
// effort command (report_kind 0) or a move-finished report (report_kind 1).
// Configuration: APB-style write/read port, registers at byte addresses 0, 4,
// 8, 12 (joint id, target mode, target value, base effort); write only while
// no item is in flight. The joint id applies at once; the other registers take
// effect when the target is latched. An accepted item waits in the input
// register until the result register is free, then its result is offered there.
// Throughput: one item per cycle while the receiver keeps up, set by the single
// input register feeding the result register; state updates along with the result.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more sample; in_ready drops only when both are full.
// Reset (rst, synchronous) returns to waiting for the first rest sample, clears
// target and drive effort, empties both registers and loads register defaults.
`default_nettype none
module motor_move_to_position_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 joint_id,
  input  logic signed [31:0]         position,
  input  logic signed [31:0]         velocity,
  input  logic signed [31:0]         measured_effort,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       report_kind,
  output logic signed [31:0]         effort_cmd,
  output logic signed [31:0]         final_position,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mmp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import mmp_pkg::*;

  cfg_t cfg;
  res_t res;
  logic res_valid;
  logic advance;
  logic slot_free;

  mmp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mmp_core u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .joint_id        (joint_id),
    .position        (position),
    .velocity        (velocity),
    .measured_effort (measured_effort),
    .slot_free       (slot_free),
    .advance         (advance),
    .res_valid       (res_valid),
    .res             (res)
  );

  mmp_out u_out (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .res_valid      (res_valid),
    .res            (res),
    .slot_free      (slot_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .report_kind    (report_kind),
    .effort_cmd     (effort_cmd),
    .final_position (final_position)
  );

endmodule
`default_nettype wire

### design/mmp_cfg.sv
`default_nettype none
module mmp_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mmp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output mmp_pkg::cfg_t              cfg
);
  import mmp_pkg::*;

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.my_joint_id  <= 8'd0;
      cfg.target_mode  <= 1'b1;
      cfg.target_value <= 32'sd0;
      cfg.base_effort  <= 31'd0;
    end else if (wr_en) begin
      unique case (idx)
        REG_JOINT_ID:  cfg.my_joint_id  <= pwdata[7:0];
        REG_TGT_MODE:  cfg.target_mode  <= pwdata[0];
        REG_TGT_VALUE: cfg.target_value <= $signed(pwdata);
        REG_BASE_EFF:  cfg.base_effort  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_JOINT_ID:  prdata = {24'd0, cfg.my_joint_id};
      REG_TGT_MODE:  prdata = {31'd0, cfg.target_mode};
      REG_TGT_VALUE: prdata = cfg.target_value;
      REG_BASE_EFF:  prdata = {1'b0, cfg.base_effort};
      default:       prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

### design/mmp_core.sv
`default_nettype none
module mmp_core (
  input  logic               clk,
  input  logic               rst,
  input  mmp_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         joint_id,
  input  logic signed [31:0] position,
  input  logic signed [31:0] velocity,
  input  logic signed [31:0] measured_effort,
  input  logic               slot_free,
  output logic               advance,
  output logic               res_valid,
  output mmp_pkg::res_t      res
);
  import mmp_pkg::*;

  // input register
  logic               s_valid;
  logic [7:0]         s_id;
  logic signed [31:0] s_pos;
  logic signed [31:0] s_vel;
  logic signed [31:0] s_eff;

  // move state
  logic [1:0]         phase, phase_next;
  logic signed [31:0] target_position, target_position_next;
  logic signed [31:0] drive_effort, drive_effort_next;

  logic               hit, at_rest;
  logic signed [32:0] tgt_sum;
  logic signed [31:0] tgt_new;
  logic signed [31:0] base_pos;
  logic signed [33:0] de_ext, eff_ext, pos_ext, tp_ext;
  logic               in_band, near, fast, slow;
  logic signed [32:0] adj_fast, adj_slow;

  assign advance  = s_valid & slot_free;
  assign in_ready = ~s_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready & in_valid) begin
      s_id  <= joint_id;
      s_pos <= position;
      s_vel <= velocity;
      s_eff <= measured_effort;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_WAIT;
      target_position <= 32'sd0;
      drive_effort    <= 32'sd0;
    end else if (advance) begin
      phase           <= phase_next;
      target_position <= target_position_next;
      drive_effort    <= drive_effort_next;
    end
  end

  assign hit     = (s_id == cfg.my_joint_id);
  assign at_rest = (s_vel == 32'sd0);

  // target latch
  assign tgt_sum  = $signed({s_pos[31], s_pos})
                  + $signed({cfg.target_value[31], cfg.target_value});
  assign tgt_new  = cfg.target_mode ? sat33(tgt_sum) : cfg.target_value;
  assign base_pos = $signed({1'b0, cfg.base_effort});

  // move tests, widened so the offsets cannot wrap
  assign de_ext  = $signed({{2{drive_effort[31]}}, drive_effort});
  assign eff_ext = $signed({{2{s_eff[31]}}, s_eff});
  assign pos_ext = $signed({{2{s_pos[31]}}, s_pos});
  assign tp_ext  = $signed({{2{target_position[31]}}, target_position});
  assign in_band = (eff_ext < de_ext + Q_WINDOW) && (eff_ext > de_ext - Q_LOW_TOL);
  assign near    = (pos_ext < tp_ext + Q_WINDOW) && (pos_ext > tp_ext - Q_WINDOW);
  assign fast    = s_vel > Q_FAST;
  assign slow    = s_vel < Q_SLOW;

  assign adj_fast = $signed({drive_effort[31], drive_effort})
                  + ((drive_effort > 32'sd0) ? -Q_STEP : Q_STEP);
  assign adj_slow = $signed({drive_effort[31], drive_effort})
                  + ((drive_effort < 32'sd0) ? -Q_STEP : Q_STEP);

  always_comb begin
    phase_next           = phase;
    target_position_next = target_position;
    drive_effort_next    = drive_effort;
    res_valid            = 1'b0;
    res.report_kind      = KIND_EFFORT;
    res.effort_cmd       = 32'sd0;
    res.final_position   = 32'sd0;
    if (hit) begin
      unique case (phase)
        PH_WAIT: begin
          if (at_rest) begin
            target_position_next = tgt_new;
            drive_effort_next    = (s_pos > tgt_new) ? -base_pos : base_pos;
            phase_next           = PH_MOVE;
          end
        end
        PH_MOVE: begin
          priority if (near) begin
            drive_effort_next = 32'sd0;
            phase_next        = PH_END;
          end else if (fast && in_band) begin
            drive_effort_next = sat33(adj_fast);
          end else if (slow && in_band) begin
            drive_effort_next = sat33(adj_slow);
          end
          res_valid      = 1'b1;
          res.effort_cmd = drive_effort_next;
        end
        PH_END: begin
          if (at_rest) begin
            res_valid          = 1'b1;
            res.report_kind    = KIND_DONE;
            res.final_position = s_pos;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/mmp_out.sv
`default_nettype none
module mmp_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               res_valid,
  input  mmp_pkg::res_t      res,
  output logic               slot_free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               report_kind,
  output logic signed [31:0] effort_cmd,
  output logic signed [31:0] final_position
);
  import mmp_pkg::*;

  res_t held;

  assign slot_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // hold the item until taken
  always_ff @(posedge clk) begin
    if (advance & res_valid) begin
      held <= res;
    end
  end

  assign report_kind    = held.report_kind;
  assign effort_cmd     = held.effort_cmd;
  assign final_position = held.final_position;

endmodule
`default_nettype wire

### design/mmp_checker.sv
`default_nettype none
`include "motor_move_to_position_unit_macros.svh"
module mmp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               report_kind,
  input logic signed [31:0] effort_cmd,
  input logic signed [31:0] final_position
);
  import mmp_pkg::*;

  // a stalled item stays offered
  `MMP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  // a done report carries no effort
  `MMP_ASSERT_IMP(a_done_zero_eff, clk, rst, out_valid && report_kind == KIND_DONE, effort_cmd == 32'sd0)
  // an effort command carries no position
  `MMP_ASSERT_IMP(a_cmd_zero_pos, clk, rst, out_valid && report_kind == KIND_EFFORT, final_position == 32'sd0)
  // reset empties the output and reopens the input
  `MMP_ASSERT_NEXT_ALWAYS(a_rst_clear, clk, rst, !out_valid && in_ready)

endmodule

bind motor_move_to_position_unit mmp_checker u_mmp_checker (.*);
`default_nettype wire

### bench/motor_move_to_position_unit_checker.sv
`default_nettype none
module motor_move_to_position_unit_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [7:0]                 joint_id,
  input  logic signed [31:0]         position,
  input  logic signed [31:0]         velocity,
  input  logic signed [31:0]         measured_effort,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       report_kind,
  input  logic signed [31:0]         effort_cmd,
  input  logic signed [31:0]         final_position,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mmp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  output int                         fail_count,
  output int                         expected_left,
  output logic signed [31:0]         drive_now,
  output logic signed [31:0]         target_now
);
  import mmp_pkg::*;

  cfg_t       cfg;
  logic [1:0] move_phase;
  res_t       pending_reports[$];

  initial fail_count = 0;

  function automatic logic signed [31:0] clip32(input longint x);
    logic signed [31:0] r;
    if (x > 64'sh7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sh8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Advance the move controller by one sample and queue any report it causes.
  task automatic step_move(input logic [7:0] id, input logic signed [31:0] pos,
                           input logic signed [31:0] vel, input logic signed [31:0] eff);
    longint p, v, e, de, t, b, step;
    logic   in_band;
    res_t   r;
    p = pos;
    v = vel;
    e = eff;
    step = Q_STEP;
    if (id != cfg.my_joint_id) return;
    case (move_phase)
      PH_WAIT: begin
        if (v == 0) begin
          if (cfg.target_mode) begin
            target_now = clip32(p + cfg.target_value);
          end else begin
            target_now = cfg.target_value;
          end
          b = cfg.base_effort;
          t = target_now;
          drive_now = clip32((p - t > 0) ? -b : b);
          move_phase = PH_MOVE;
        end
      end
      PH_END: begin
        if (v == 0) begin
          r.report_kind = KIND_DONE;
          r.effort_cmd = '0;
          r.final_position = pos;
          pending_reports.push_back(r);
        end
      end
      PH_MOVE: begin
        de = drive_now;
        t = target_now;
        in_band = (e < de + Q_WINDOW) && (e > de - Q_LOW_TOL);
        if (p < t + Q_WINDOW && p > t - Q_WINDOW) begin
          drive_now = '0;
          move_phase = PH_END;
        end else if (v > Q_FAST && in_band) begin
          drive_now = clip32(de + ((de > 0) ? -step : step));
        end else if (v < Q_SLOW && in_band) begin
          drive_now = clip32(de + ((de < 0) ? -step : step));
        end
        r.report_kind = KIND_EFFORT;
        r.effort_cmd = drive_now;
        r.final_position = '0;
        pending_reports.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic check_report;
    res_t want;
    if (pending_reports.size() == 0) begin
      $display("%0t: report with none expected: kind %0d effort %0d position %0d",
               $time, report_kind, effort_cmd, final_position);
      fail_count++;
      return;
    end
    want = pending_reports.pop_front();
    if (report_kind !== want.report_kind) begin
      $display("%0t: report_kind expected %0d actual %0d", $time, want.report_kind,
               report_kind);
      fail_count++;
    end
    if (effort_cmd !== want.effort_cmd) begin
      $display("%0t: effort_cmd expected %0d actual %0d", $time, want.effort_cmd, effort_cmd);
      fail_count++;
    end
    if (final_position !== want.final_position) begin
      $display("%0t: final_position expected %0d actual %0d", $time, want.final_position,
               final_position);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg.my_joint_id = '0;
      cfg.target_mode = 1'b1;
      cfg.target_value = '0;
      cfg.base_effort = '0;
      move_phase = PH_WAIT;
      target_now = '0;
      drive_now = '0;
      pending_reports.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_JOINT_ID:  cfg.my_joint_id = pwdata[7:0];
          REG_TGT_MODE:  cfg.target_mode = pwdata[0];
          REG_TGT_VALUE: cfg.target_value = pwdata;
          REG_BASE_EFF:  cfg.base_effort = pwdata[30:0];
          default: ;
        endcase
      end
      // results leave only after passing the input and result registers, so pop before push
      if (out_valid && out_ready) check_report();
      if (in_valid && in_ready) step_move(joint_id, position, velocity, measured_effort);
    end
    expected_left = pending_reports.size();
  end

endmodule
`default_nettype wire

### bench/motor_move_to_position_unit_test.sv
`default_nettype none
module motor_move_to_position_unit_test;
  import mmp_pkg::*;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [7:0]                 joint_id = '0;
  logic signed [31:0]         position = '0;
  logic signed [31:0]         velocity = '0;
  logic signed [31:0]         measured_effort = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       report_kind;
  logic signed [31:0]         effort_cmd;
  logic signed [31:0]         final_position;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [ADDR_W-1:0]          paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  int                 fail_count;
  int                 expected_left;
  logic signed [31:0] drive_now;
  logic signed [31:0] target_now;

  int                 send_idle = 25;
  int                 recv_idle = 84;
  logic [7:0]         cur_id;
  logic               mode;
  logic signed [31:0] tv;
  logic signed [31:0] rest;
  logic [30:0]        base;

  motor_move_to_position_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .joint_id(joint_id), .position(position), .velocity(velocity),
    .measured_effort(measured_effort),
    .out_valid(out_valid), .out_ready(out_ready),
    .report_kind(report_kind), .effort_cmd(effort_cmd), .final_position(final_position),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  motor_move_to_position_unit_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .joint_id(joint_id), .position(position), .velocity(velocity),
    .measured_effort(measured_effort),
    .out_valid(out_valid), .out_ready(out_ready),
    .report_kind(report_kind), .effort_cmd(effort_cmd), .final_position(final_position),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .fail_count(fail_count), .expected_left(expected_left),
    .drive_now(drive_now), .target_now(target_now)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle);

  function automatic logic signed [31:0] clamp_s32(input longint x);
    logic signed [31:0] r;
    if (x > S32_MAX) begin
      r = S32_MAX;
    end else if (x < S32_MIN) begin
      r = S32_MIN;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // measured effort at a given offset from the effort now being commanded
  function automatic logic signed [31:0] eff_off(input longint off);
    return clamp_s32(longint'(drive_now) + off);
  endfunction

  // position outside the stop window around the target
  function automatic logic signed [31:0] far_pos(input logic signed [31:0] t);
    longint x, tl;
    tl = t;
    do begin
      case ($urandom_range(0, 5))
        0: x = tl + 6554;
        1: x = tl - 6554;
        2: x = tl + 6554 + longint'($urandom_range(0, 1000000));
        3: x = tl - 6554 - longint'($urandom_range(0, 1000000));
        4: x = $urandom_range(0, 1) ? S32_MAX : S32_MIN;
        default: x = longint'(signed'($urandom));
      endcase
    end while (x > S32_MAX || x < S32_MIN || (x < tl + 6554 && x > tl - 6554));
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] pick_velocity();
    logic signed [31:0] v;
    case ($urandom_range(0, 11))
      0: v = '0;
      1: v = Q_FAST;
      2: v = Q_FAST + 1;
      3: v = Q_SLOW;
      4: v = Q_SLOW - 1;
      5, 6, 7: v = Q_FAST + 1 + $urandom_range(0, 32'h00FF_FFFF);
      8: v = $urandom_range(0, 65535);
      9: v = -32'sd1 - $urandom_range(0, 32'h00FF_FFFF);
      10: v = $urandom;
      default: v = $urandom_range(0, 1) ? S32_MAX : S32_MIN;
    endcase
    return v;
  endfunction

  task automatic send_sample(input logic [7:0] id, input logic signed [31:0] p,
                             input logic signed [31:0] v, input logic signed [31:0] e);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    joint_id <= id;
    position <= p;
    velocity <= v;
    measured_effort <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_moving;
    logic [7:0]         id;
    logic signed [31:0] v;
    logic signed [31:0] e;
    id = ($urandom_range(0, 99) < 90) ? cur_id : 8'($urandom);
    v = pick_velocity();
    case ($urandom_range(0, 7))
      0: e = eff_off(-3277 + longint'($urandom_range(0, 1)));
      1: e = eff_off(6553 + longint'($urandom_range(0, 1)));
      2: e = $urandom;
      default: e = eff_off(-3276 + longint'($urandom_range(0, 9829)));
    endcase
    send_sample(id, far_pos(target_now), v, e);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // let every outstanding item through before touching the registers
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_left != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // register extremes while waiting: none of these samples latches a target
    cur_id = 8'd255;
    cfg_write(REG_JOINT_ID, 32'(cur_id));
    cfg_write(REG_TGT_MODE, 32'd0);
    cfg_write(REG_TGT_VALUE, S32_MIN);
    cfg_write(REG_BASE_EFF, 32'h7FFF_FFFF);
    send_sample(cur_id, S32_MAX, S32_MIN, '0);
    send_sample(8'd0, '0, '0, S32_MAX);
    send_sample(cur_id, S32_MIN, 32'sd1, S32_MIN);
    drain();
    cur_id = 8'd0;
    cfg_write(REG_JOINT_ID, 32'(cur_id));
    cfg_write(REG_TGT_MODE, 32'd1);
    cfg_write(REG_TGT_VALUE, S32_MAX);
    cfg_write(REG_BASE_EFF, 32'd0);
    send_sample(cur_id, '0, -32'sd1, '0);
    send_sample(8'd255, '0, '0, '0);
    send_sample(cur_id, S32_MAX, S32_MAX, S32_MAX);
    drain();

    // setting for the one move of the run
    case ($urandom_range(0, 4))
      0: begin
        mode = 1'b1;
        tv = 32'sh7FFF_0000 + $urandom_range(0, 65535);
        rest = 32'sh4000_0000 + $urandom_range(0, 32'h3FFF_FFFF);
      end
      1: begin
        mode = 1'b1;
        tv = S32_MIN;
        rest = -32'sd1 - $urandom_range(0, 32'h3FFF_FFFF);
      end
      2: begin
        mode = 1'b1;
        tv = $urandom;
        rest = $urandom;
      end
      3: begin
        mode = 1'b0;
        tv = $urandom;
        rest = tv;
      end
      default: begin
        mode = 1'b0;
        tv = $urandom;
        rest = $urandom;
      end
    endcase
    case ($urandom_range(0, 3))
      0: base = '0;
      1: base = 31'h7FFF_FFFF;
      2: base = 31'(66 * $urandom_range(1, 40));
      default: base = $urandom;
    endcase
    cur_id = $urandom;
    cfg_write(REG_JOINT_ID, 32'(cur_id));
    cfg_write(REG_TGT_MODE, 32'(mode));
    cfg_write(REG_TGT_VALUE, tv);
    cfg_write(REG_BASE_EFF, {1'b0, base});
    send_sample(cur_id, rest, '0, $urandom);

    // band edges and velocity thresholds while moving
    send_sample(cur_id, far_pos(target_now), Q_FAST + 1, eff_off(-3276));
    send_sample(cur_id, far_pos(target_now), Q_FAST + 1, eff_off(6553));
    send_sample(cur_id, far_pos(target_now), Q_FAST + 1, eff_off(-3277));
    send_sample(cur_id, far_pos(target_now), Q_FAST + 1, eff_off(6554));
    send_sample(cur_id, far_pos(target_now), Q_FAST, eff_off(0));
    send_sample(cur_id, far_pos(target_now), Q_SLOW, eff_off(0));
    send_sample(cur_id, far_pos(target_now), Q_SLOW - 1, eff_off(0));
    send_sample(cur_id, far_pos(target_now), '0, eff_off(0));
    send_sample(cur_id, far_pos(target_now), S32_MIN, eff_off(0));
    send_sample(cur_id, far_pos(target_now), S32_MAX, eff_off(0));
    send_sample(cur_id + 8'd1, target_now, '0, '0);

    repeat (200) send_moving();
    drain();

    // late writes leave the move under way alone, apart from the joint filter
    send_idle = 84;
    recv_idle = 25;
    cur_id = $urandom;
    cfg_write(REG_JOINT_ID, 32'(cur_id));
    cfg_write(REG_TGT_MODE, 32'($urandom_range(0, 1)));
    cfg_write(REG_TGT_VALUE, $urandom);
    cfg_write(REG_BASE_EFF, {1'b0, 31'($urandom)});
    repeat (230) send_moving();
    drain();

    send_idle = 0;
    recv_idle = 0;
    repeat (200) send_moving();
    // stop inside the window, then report at rest
    send_sample(cur_id, clamp_s32(longint'(target_now) - 6553 +
                                  longint'($urandom_range(0, 13106))),
                pick_velocity(), $urandom);
    repeat (45) begin
      send_sample(($urandom_range(0, 9) < 9) ? cur_id : 8'($urandom), $urandom,
                  ($urandom_range(0, 4) < 4) ? 32'sd0 : 32'($urandom), $urandom);
    end
    in_valid <= 1'b0;

    while (expected_left != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

### motor_move_to_position_unit.f
+incdir+design
design/mmp_pkg.sv
design/mmp_cfg.sv
design/mmp_core.sv
design/mmp_out.sv
design/motor_move_to_position_unit.sv
design/mmp_checker.sv
bench/motor_move_to_position_unit_checker.sv
bench/motor_move_to_position_unit_test.sv
